/* sv/extended_disk_image_header_check_core_defines.svh */
// Assertion macros for the extended disk image header check core.
`ifndef EXTENDED_DISK_IMAGE_HEADER_CHECK_CORE_DEFINES_SVH
`define EXTENDED_DISK_IMAGE_HEADER_CHECK_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define EHC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define EHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define EHC_ASSERT_IMPLY(label, ante, cons)
`define EHC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/ehc_pkg.sv */
// Shared constants and types of the disk image header check core.
package ehc_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    localparam logic [15:0] MIN_TRACKS     = 16'd160;
    localparam logic [15:0] MAX_TRACKS     = 16'd168;
    localparam logic [3:0]  ENTRY_LAST     = 4'd11;
    localparam logic [3:0]  ENTRY_TYPE_END = 4'd3;
    localparam logic [31:0] STD_TRACK_BITS = 32'(11 * 512 * 8);
    localparam logic [31:0] HD_BITS        = 32'(16000 * 8);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SIGNATURE = 2'd1;
    localparam logic [1:0] ST_CORRUPT   = 2'd2;
    localparam logic [1:0] ST_TRACK_FMT = 2'd3;

    localparam logic [7:0] MAGIC [9] = '{
        8'h55, 8'h41, 8'h45, 8'h2D, 8'h31, 8'h41, 8'h44, 8'h46, 8'h00
    };

    typedef struct packed {
        logic        sig_ok;
        logic        ranged;
        logic [15:0] tracks;
        logic [39:0] sum;
        logic [31:0] largest;
        logic [1:0]  err;
        logic [7:0]  trunc;
    } fin_t;

endpackage

/* sv/ehc_parse.sv */
// Per-byte header parser: signature, track count and track entry checks.
module ehc_parse import ehc_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic [7:0]             data_byte,
    input  logic                   last,
    output fin_t                   fin,
    output logic [LENGTH_BITS-1:0] fin_len
);

    typedef enum logic [1:0] {CLS_STD, CLS_EXT, CLS_OTHER} track_class_t;

    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic                   sig_reg, sig_next;
    logic [15:0]            trk_reg, trk_next;
    logic [55:0]            shift_reg, shift_next;
    logic [39:0]            sum_reg, sum_next;
    logic [31:0]            big_reg, big_next;
    logic [1:0]             err_reg, err_next;
    logic [7:0]             trunc_reg, trunc_next;
    track_class_t           cls_reg, cls_next;
    logic [3:0]             off_reg, off_next;
    logic [7:0]             idx_reg, idx_next;
    fin_t                   fin_reg, fin_next;
    logic [LENGTH_BITS-1:0] len_reg;

    logic        ranged;
    logic        in_entries;
    logic        parse_en;
    logic [31:0] avail;
    logic [31:0] used;
    logic [15:0] ttype;

    assign ranged     = (trk_reg >= MIN_TRACKS) && (trk_reg <= MAX_TRACKS);
    assign in_entries = pos_reg >= LENGTH_BITS'(12);
    assign parse_en   = in_entries && ranged && ({8'd0, idx_reg} < trk_reg);
    assign avail      = shift_reg[55:24];
    assign used       = {shift_reg[23:0], data_byte};
    assign ttype      = {shift_reg[7:0], data_byte};

    always_comb
    begin
        pos_next   = (pos_reg == '1) ? pos_reg : pos_reg + LENGTH_BITS'(1);
        sig_next   = sig_reg;
        trk_next   = trk_reg;
        shift_next = shift_reg;
        sum_next   = sum_reg;
        big_next   = big_reg;
        err_next   = err_reg;
        trunc_next = trunc_reg;
        cls_next   = cls_reg;
        off_next   = off_reg;
        idx_next   = idx_reg;

        if (pos_reg < LENGTH_BITS'(9))
        begin
            if (data_byte != MAGIC[pos_reg[3:0]])
            begin
                sig_next = 1'b0;
            end
        end
        else if (pos_reg == LENGTH_BITS'(10))
        begin
            trk_next = {data_byte, trk_reg[7:0]};
        end
        else if (pos_reg == LENGTH_BITS'(11))
        begin
            trk_next = {trk_reg[15:8], data_byte};
        end

        if (in_entries && ({8'd0, idx_reg} < MAX_TRACKS))
        begin
            if (off_reg == ENTRY_LAST)
            begin
                off_next = '0;
                idx_next = idx_reg + 8'd1;
            end
            else
            begin
                off_next = off_reg + 4'd1;
            end
        end

        if (parse_en)
        begin
            shift_next = {shift_reg[47:0], data_byte};
            if (off_reg == ENTRY_TYPE_END)
            begin
                priority if (ttype == 16'd0) cls_next = CLS_STD;
                else if (ttype == 16'd1)     cls_next = CLS_EXT;
                else                         cls_next = CLS_OTHER;
            end
            else if (off_reg == ENTRY_LAST)
            begin
                sum_next = sum_reg + 40'(avail);
                if (used > big_reg)
                begin
                    big_next = used;
                end
                if (err_reg == ST_OK)
                begin
                    priority if (cls_reg == CLS_OTHER)
                        err_next = ST_TRACK_FMT;
                    else if (cls_reg == CLS_STD && used != STD_TRACK_BITS)
                        err_next = ST_CORRUPT;
                    else if (35'(used) > {avail, 3'b000})
                        err_next = ST_CORRUPT;
                    else if (used[2:0] != 3'd0)
                        trunc_next = trunc_reg + 8'd1;
                    else
                        trunc_next = trunc_reg;
                end
            end
        end

        fin_next.sig_ok  = sig_next && (pos_next >= LENGTH_BITS'(9));
        fin_next.ranged  = (trk_next >= MIN_TRACKS) && (trk_next <= MAX_TRACKS);
        fin_next.tracks  = trk_next;
        fin_next.sum     = sum_next;
        fin_next.largest = big_next;
        fin_next.err     = err_next;
        fin_next.trunc   = trunc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sig_reg   <= 1'b1;
            trk_reg   <= '0;
            shift_reg <= '0;
            sum_reg   <= '0;
            big_reg   <= '0;
            err_reg   <= ST_OK;
            trunc_reg <= '0;
            cls_reg   <= CLS_STD;
            off_reg   <= '0;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                pos_reg   <= '0;
                sig_reg   <= 1'b1;
                trk_reg   <= '0;
                shift_reg <= '0;
                sum_reg   <= '0;
                big_reg   <= '0;
                err_reg   <= ST_OK;
                trunc_reg <= '0;
                cls_reg   <= CLS_STD;
                off_reg   <= '0;
                idx_reg   <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                sig_reg   <= sig_next;
                trk_reg   <= trk_next;
                shift_reg <= shift_next;
                sum_reg   <= sum_next;
                big_reg   <= big_next;
                err_reg   <= err_next;
                trunc_reg <= trunc_next;
                cls_reg   <= cls_next;
                off_reg   <= off_next;
                idx_reg   <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last)
        begin
            fin_reg <= fin_next;
            len_reg <= pos_next;
        end
    end

    assign fin     = fin_reg;
    assign fin_len = len_reg;

endmodule

/* sv/extended_disk_image_header_check_core.sv */
// Top level of the extended disk image header check core.
// A result is registered in the parser, then in the output stage; a stall between
// the two holds it. Throughput: one byte per cycle while in_ready is high.
// A following file may start in the cycle after a last byte unless the output stalls.
// Reset (rst_n low, asynchronous) clears parser state and both valid flags.
module extended_disk_image_header_check_core import ehc_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        high_density,
    output logic [15:0] track_count,
    output logic [15:0] cylinders,
    output logic [7:0]  truncated_tracks
);

`include "extended_disk_image_header_check_core_defines.svh"

    localparam int CW = ((LENGTH_BITS > 41) ? LENGTH_BITS : 41) + 1;

    fin_t                   fin;
    logic [LENGTH_BITS-1:0] fin_len;
    logic                   take;
    logic                   fin_vld_reg;
    logic                   fin_adv;
    logic                   out_vld_reg;

    logic [19:0]   header;
    logic [CW-1:0] expect_len;
    logic [CW-1:0] len_x;
    logic          mismatch;
    logic [1:0]    status_next;

    logic [1:0]  status_reg;
    logic        hd_reg;
    logic [15:0] trk_reg;
    logic [15:0] cyl_reg;
    logic [7:0]  trunc_reg;

    assign fin_adv  = fin_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !fin_vld_reg || fin_adv;
    assign take     = in_valid && in_ready;

    ehc_parse #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .last      (last),
        .fin       (fin),
        .fin_len   (fin_len)
    );

    assign header     = 20'({fin.tracks, 3'b000}) + 20'({fin.tracks, 2'b00}) + 20'd12;
    assign expect_len = CW'(header) + CW'(fin.sum);
    assign len_x      = CW'(fin_len);
    assign mismatch   = (fin_len == '1) || (len_x < CW'(header)) || (len_x != expect_len);

    always_comb
    begin
        priority if (!fin.sig_ok) status_next = ST_SIGNATURE;
        else if (!fin.ranged)     status_next = ST_CORRUPT;
        else if (mismatch)        status_next = ST_CORRUPT;
        else                      status_next = fin.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (take && last)
            begin
                fin_vld_reg <= 1'b1;
            end
            else if (fin_adv)
            begin
                fin_vld_reg <= 1'b0;
            end

            if (fin_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_adv)
        begin
            status_reg <= status_next;
            hd_reg     <= fin.ranged && (fin.largest >= HD_BITS);
            trk_reg    <= fin.tracks;
            cyl_reg    <= 16'((17'(fin.tracks) + 17'd1) >> 1);
            trunc_reg  <= fin.ranged ? fin.trunc : 8'd0;
        end
    end

    assign out_valid        = out_vld_reg;
    assign status           = status_reg;
    assign high_density     = hd_reg;
    assign track_count      = trk_reg;
    assign cylinders        = cyl_reg;
    assign truncated_tracks = trunc_reg;

    `EHC_ASSERT_IMPLY(a_stall_only_when_full, !in_ready, fin_vld_reg && out_vld_reg)
    `EHC_ASSERT_NEXT(a_last_fills_fin, take && last, fin_vld_reg)
    `EHC_ASSERT_IMPLY(a_ok_in_range, out_valid && (status == ST_OK),
        (track_count >= MIN_TRACKS) && (track_count <= MAX_TRACKS))
    `EHC_ASSERT_IMPLY(a_out_of_range_empty,
        out_valid && ((track_count < MIN_TRACKS) || (track_count > MAX_TRACKS)),
        !high_density && (truncated_tracks == 8'd0))
    `EHC_ASSERT_IMPLY(a_trunc_bounded, out_valid && (status == ST_OK),
        {8'd0, truncated_tracks} <= track_count)

endmodule
